// ===== rtl/core/pbc_pkg.sv =====
package pbc_pkg;

  // Field widths
  localparam int unsigned ChanW  = 6;
  localparam int unsigned LevelW = 5;
  localparam int unsigned CurveW = 8;
  localparam int unsigned WeightW = 4;

  // Brightness levels
  localparam logic [LevelW-1:0] LevelNeutral = 5'd8;
  localparam logic [LevelW-1:0] LevelMax     = 5'd16;

  // Full blend weight; the curve weight and the identity weight add up to it
  localparam logic [WeightW-1:0] WeightFull = 4'd8;

  // Input item: one palette entry
  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } pbc_in_t;

  // Result item: corrected palette entry
  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
  } pbc_out_t;

  // Lane control, decoded once from the brightness register
  typedef struct packed {
    logic               up;      // 1: brightening curve, 0: darkening curve
    logic [WeightW-1:0] weight;  // curve weight 0..8
  } pbc_ctl_t;

  // Brightening curve floor(sqrt(1024*x)) = floor(32*sqrt(x)) for x in 0..63
  localparam logic [CurveW-1:0] UpLut [64] = '{
    8'd0,   8'd32,  8'd45,  8'd55,  8'd64,  8'd71,  8'd78,  8'd84,
    8'd90,  8'd96,  8'd101, 8'd106, 8'd110, 8'd115, 8'd119, 8'd123,
    8'd128, 8'd131, 8'd135, 8'd139, 8'd143, 8'd146, 8'd150, 8'd153,
    8'd156, 8'd160, 8'd163, 8'd166, 8'd169, 8'd172, 8'd175, 8'd178,
    8'd181, 8'd183, 8'd186, 8'd189, 8'd192, 8'd194, 8'd197, 8'd199,
    8'd202, 8'd204, 8'd207, 8'd209, 8'd212, 8'd214, 8'd217, 8'd219,
    8'd221, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232, 8'd235, 8'd237,
    8'd239, 8'd241, 8'd243, 8'd245, 8'd247, 8'd249, 8'd251, 8'd253
  };

endpackage

// ===== rtl/core/pbc_lane.sv =====
module pbc_lane
  import pbc_pkg::*;
(
  input  logic [ChanW-1:0] chan_i,
  input  pbc_ctl_t         ctl_i,
  output logic [ChanW-1:0] chan_o
);

  logic [CurveW-1:0]  v;
  logic [11:0]        sq;
  logic [CurveW-1:0]  curve;
  logic [WeightW-1:0] id_weight;
  logic [11:0]        sum;

  // Scaled channel and the selected curve value
  assign v  = {chan_i, 2'b00};
  assign sq = {6'd0, chan_i} * {6'd0, chan_i};

  always_comb begin
    if (ctl_i.up) begin
      curve = UpLut[chan_i];
    end else begin
      // (4x)^2 / 256 reduces to x^2 / 16
      curve = sq[11:4];
    end
  end

  // Weighted blend; /8 then /4 is one shift by five
  assign id_weight = WeightFull - ctl_i.weight;
  assign sum = ({8'd0, ctl_i.weight} * {4'd0, curve})
             + ({8'd0, id_weight} * {4'd0, v});
  assign chan_o = sum[10:5];

endmodule

// ===== rtl/core/pbc_merge.sv =====
module pbc_merge
  import pbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pbc_out_t         out_data_o
);

  pbc_out_t res;
  pbc_out_t out_data_q, out_data_d;
  pbc_out_t skid_data_q, skid_data_d;
  logic     out_vq, out_vd;
  logic     skid_vq, skid_vd;
  logic     accept;
  logic     out_free;

  // Gather the lane results into one item
  assign res.red_out   = red_i;
  assign res.green_out = green_i;
  assign res.blue_out  = blue_i;

  assign accept   = in_valid_i & ~skid_vq;
  assign out_free = ~out_vq | ~out_stall_i;

  // Output register plus one skid entry
  always_comb begin
    out_vd      = out_vq;
    out_data_d  = out_data_q;
    skid_vd     = skid_vq;
    skid_data_d = skid_data_q;
    if (out_free) begin
      if (skid_vq) begin
        out_vd     = 1'b1;
        out_data_d = skid_data_q;
        skid_vd    = 1'b0;
      end else begin
        out_vd     = accept;
        out_data_d = res;
      end
    end else if (accept) begin
      skid_vd     = 1'b1;
      skid_data_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else begin
      out_vq  <= out_vd;
      skid_vq <= skid_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign in_stall_o  = skid_vq;
  assign out_valid_o = out_vq;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // Skid entry only holds an item behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vq |-> out_vq)
    else $error("skid valid without output valid");

  // Skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vq) |-> $past(out_vq && out_stall_i))
    else $error("skid filled while output was free");

  // Taken output with a skid item moves it forward
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && !out_stall_i && skid_vq |=> out_vq && !skid_vq)
    else $error("skid item not moved to output");

  // Item into an empty output shows up next cycle
  a_fill_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !out_vq |=> out_vq)
    else $error("accepted item lost");
`endif

endmodule

// ===== rtl/core/palette_brightness_curve_core.sv =====
// An accepted item is registered in the output register, or in the skid entry
// while the output stalls. Throughput: 1 item per cycle unless stalled; three
// lanes in parallel, each a table lookup or small square, then a weighted blend.
// A two-entry output stage (register plus skid) takes one more item on a stall.
// Reset (rst_ni low, asynchronous): output and skid empty, brightness = 8.
module palette_brightness_curve_core
  import pbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LevelW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pbc_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pbc_out_t          out_data_o
);

  logic [LevelW-1:0] level_q, level_d;
  logic [LevelW-1:0] level_sat;
  logic [LevelW-1:0] diff;
  pbc_ctl_t          ctl;
  logic [ChanW-1:0]  red_res, green_res, blue_res;

  // Brightness register
  assign level_d = cfg_we_i ? cfg_wdata_i : level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LevelNeutral;
    end else begin
      level_q <= level_d;
    end
  end

  // Curve selection and weight; levels above 16 act as 16
  always_comb begin
    level_sat = (level_q > LevelMax) ? LevelMax : level_q;
    if (level_sat > LevelNeutral) begin
      ctl.up = 1'b1;
      diff   = level_sat - LevelNeutral;
    end else begin
      ctl.up = 1'b0;
      diff   = LevelNeutral - level_sat;
    end
    ctl.weight = diff[WeightW-1:0];
  end

  // Channel lanes
  pbc_lane u_lane_red (
    .chan_i (in_data_i.red_in),
    .ctl_i  (ctl),
    .chan_o (red_res)
  );

  pbc_lane u_lane_green (
    .chan_i (in_data_i.green_in),
    .ctl_i  (ctl),
    .chan_o (green_res)
  );

  pbc_lane u_lane_blue (
    .chan_i (in_data_i.blue_in),
    .ctl_i  (ctl),
    .chan_o (blue_res)
  );

  // Merge and output staging
  pbc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_res),
    .green_i     (green_res),
    .blue_i      (blue_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/palette_brightness_curve_checker.sv =====
module palette_brightness_curve_checker
  import pbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LevelW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  pbc_in_t           in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  pbc_out_t          out_data_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       waiting_count_o
);

  // Shadow of the brightness register
  logic [LevelW-1:0] level_q;

  // Corrected entries still owed by the block, oldest first
  pbc_out_t corrected_q[$];

  pbc_out_t    want;
  int unsigned errs;

  // floor(sqrt(n)) by plain search; n stays below 2^16 here
  function automatic int unsigned floor_sqrt(int unsigned n);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  // One channel: scale to 4x, blend with the selected curve, scale back
  function automatic logic [ChanW-1:0] corrected_channel(logic [ChanW-1:0] x,
                                                         logic [LevelW-1:0] lvl);
    int unsigned v;
    int unsigned lv;
    int unsigned w;
    int unsigned curve;
    int unsigned mix;
    v  = 4 * x;
    lv = (lvl > LevelMax) ? LevelMax : lvl;  // levels above sixteen saturate
    if (lv > LevelNeutral) begin
      w     = lv - LevelNeutral;
      curve = floor_sqrt(256 * v);
      if (curve > 255) curve = 255;
      mix   = (w * curve + (WeightFull - w) * v) / WeightFull;
    end else if (lv < LevelNeutral) begin
      w     = LevelNeutral - lv;
      curve = (v * v) / 256;
      if (curve > 255) curve = 255;
      mix   = (w * curve + (WeightFull - w) * v) / WeightFull;
    end else begin
      mix = v;
    end
    return ChanW'(mix / 4);
  endfunction

  function automatic pbc_out_t corrected_entry(pbc_in_t e, logic [LevelW-1:0] lvl);
    pbc_out_t r;
    r.red_out   = corrected_channel(e.red_in, lvl);
    r.green_out = corrected_channel(e.green_in, lvl);
    r.blue_out  = corrected_channel(e.blue_in, lvl);
    return r;
  endfunction

  // Watch both channels; predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LevelNeutral;
      corrected_q.delete();
      mismatch_count_o <= 0;
      waiting_count_o  <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) level_q <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) corrected_q.push_back(corrected_entry(in_data_i, level_q));
      if (out_valid_i && !out_stall_i) begin
        if (corrected_q.size() == 0) begin
          $error("result with no item waiting: %0h", out_data_i);
          errs++;
        end else begin
          want = corrected_q.pop_front();
          if (out_data_i.red_out !== want.red_out) begin
            $error("red_out: expected %0d, got %0d", want.red_out, out_data_i.red_out);
            errs++;
          end
          if (out_data_i.green_out !== want.green_out) begin
            $error("green_out: expected %0d, got %0d", want.green_out, out_data_i.green_out);
            errs++;
          end
          if (out_data_i.blue_out !== want.blue_out) begin
            $error("blue_out: expected %0d, got %0d", want.blue_out, out_data_i.blue_out);
            errs++;
          end
        end
      end
      mismatch_count_o <= mismatch_count_o + errs;
      waiting_count_o  <= corrected_q.size();
    end
  end

endmodule

// ===== dv/palette_brightness_curve_core_test.sv =====
module palette_brightness_curve_core_test;
  import pbc_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [LevelW-1:0] cfg_wdata_i = LevelNeutral;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pbc_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pbc_out_t          out_data_o;

  int unsigned mismatch_count;
  int unsigned waiting_count;

  // Idling controls for the sender and the receiver
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;
  int unsigned holdoff_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  palette_brightness_curve_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  palette_brightness_curve_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .waiting_count_o  (waiting_count)
  );

  // Receiver: long hold-off when asked, else random stalls unless quiet
  initial begin
    forever begin
      @(posedge clk_i);
      if (holdoff_cycles > 0) begin
        out_stall_i <= 1'b1;
        holdoff_cycles--;
      end else if (receiver_quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 7);
      end
    end
  end

  // Offer one palette entry and wait until the block takes it
  task automatic send_entry(pbc_in_t e);
    if (!sender_quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop offering and wait until every corrected entry has come back
  task automatic drain_entries();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (waiting_count != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_level(logic [LevelW-1:0] lvl);
    drain_entries();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lvl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [ChanW-1:0] random_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(0, 63));
    endcase
  endfunction

  // Extremes and alternating bit patterns at one level
  task automatic send_corner_entries(logic [LevelW-1:0] lvl);
    write_level(lvl);
    send_entry('{red_in: 6'd0, green_in: 6'd0, blue_in: 6'd0});
    send_entry('{red_in: 6'd63, green_in: 6'd63, blue_in: 6'd63});
    send_entry('{red_in: 6'h2a, green_in: 6'h15, blue_in: 6'd1});
    send_entry('{red_in: 6'd62, green_in: 6'd32, blue_in: 6'd31});
  endtask

  initial begin
    logic [LevelW-1:0] phase_level [12];
    pbc_in_t           e;
    phase_level = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd3, 5'd12,
                    5'd8, 5'd7, 5'd9, 5'd1, 5'd15, 5'd24};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: neutral at reset, both curve ends, level above sixteen
    send_entry('{red_in: 6'd63, green_in: 6'd0, blue_in: 6'h2a});
    send_entry('{red_in: 6'd0, green_in: 6'd63, blue_in: 6'h15});
    send_corner_entries(LevelMax);
    send_corner_entries(5'd0);
    send_corner_entries(5'd31);
    send_corner_entries(5'd4);
    send_corner_entries(LevelNeutral);

    // Random phases, one level each, drained before each level change
    for (int p = 0; p < 12; p++) begin
      write_level((p < 10) ? phase_level[p] : LevelW'($urandom_range(0, 31)));
      sender_quiet   = (p == 2);
      receiver_quiet = (p == 2);
      if (p == 4 || p == 9) holdoff_cycles = 60;
      for (int i = 0; i < 100; i++) begin
        e.red_in   = random_channel();
        e.green_in = random_channel();
        e.blue_in  = random_channel();
        send_entry(e);
      end
    end

    drain_entries();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("palette_brightness_curve_core_test passed");
    end else begin
      $display("palette_brightness_curve_core_test failed");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #200000;
    $display("palette_brightness_curve_core_test failed");
    $finish;
  end

endmodule
